// ----- rtl/ternary_prefix_trigraph_codec_macros.svh -----
// ============================================================================
// ternary_prefix_trigraph_codec_macros.svh
// Assertion macros for the trigraph codec; empty when SYNTH is defined.
// ============================================================================
`ifndef TERNARY_PREFIX_TRIGRAPH_CODEC_MACROS_SVH
`define TERNARY_PREFIX_TRIGRAPH_CODEC_MACROS_SVH
`ifndef SYNTH
// a implies c in the same cycle
`define TPTC_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// a implies c in the next cycle, checked through reset as well
`define TPTC_ASSERT_NEXT(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TPTC_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define TPTC_ASSERT_NEXT(lbl, clk, a, c)
`endif
`endif

// ----- rtl/tptc_pkg.sv -----
// ============================================================================
// tptc_pkg
// Types, constants and code table helpers shared by the trigraph codec.
// ============================================================================
`default_nettype none
package tptc_pkg;

  localparam int LETTER_W   = 5;
  localparam int OUT_CNT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;
  localparam int NUM_LETTERS = 26;
  localparam int MAX_CODE_DIGITS = 6;
  localparam int RUN_CODE_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILLER    = 3'd4;

  // prefix-free code per letter, written as decimal digit strings
  localparam int CODE_DEC [NUM_LETTERS] = '{
    13, 32112, 1112, 213, 31, 3213, 32113, 113,
    322, 321112, 11112, 212, 2111, 23, 22, 3212,
    11113, 323, 112, 12, 1113, 11111, 2112, 321111,
    2113, 321113
  };

  // number of digits in a letter's code
  function automatic int code_len(int l);
    int t;
    int n;
    t = CODE_DEC[l];
    n = 0;
    for (int i = 0; i < MAX_CODE_DIGITS; i++) begin
      if (t > 0) begin
        n = n + 1;
        t = t / 10;
      end
    end
    return n;
  endfunction

  // code digits packed two bits each, first digit in the low bits
  function automatic logic [2*MAX_CODE_DIGITS-1:0] code_digw(int l);
    int t;
    int n;
    logic [2*MAX_CODE_DIGITS-1:0] w;
    n = code_len(l);
    t = CODE_DEC[l];
    w = '0;
    for (int i = MAX_CODE_DIGITS - 1; i >= 0; i--) begin
      if (i < n) begin
        w[2*i +: 2] = 2'(t % 10);
        t = t / 10;
      end
    end
    return w;
  endfunction

  // parse value: leading one, then the digits in base four
  function automatic logic [RUN_CODE_W-1:0] code_val(int l);
    logic [RUN_CODE_W-1:0] v;
    logic [2*MAX_CODE_DIGITS-1:0] w;
    int n;
    n = code_len(l);
    w = code_digw(l);
    v = RUN_CODE_W'(1);
    for (int i = 0; i < MAX_CODE_DIGITS; i++) begin
      if (i < n) v = {v[RUN_CODE_W-3:0], w[2*i +: 2]};
    end
    return v;
  endfunction

  typedef struct packed {
    logic [LETTER_W-1:0]  letter;
    logic                 has_letter;
    logic                 token_legal;
    logic                 run_last;
    logic [OUT_CNT_W-1:0] token_count;
    logic [OUT_CNT_W-1:0] legal_count;
  } result_t;

  // all results of one letter beat
  typedef struct packed {
    result_t [2:0] slot;
    logic [1:0]    num;
  } bundle_t;

endpackage
`default_nettype wire

// ----- rtl/tptc_front.sv -----
// ============================================================================
// tptc_front
// Takes letter beats, holds message state and builds the result bundle.
// ============================================================================
`default_nettype none
module tptc_front #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  input  wire logic [tptc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tptc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             take,
  input  wire logic [tptc_pkg::LETTER_W-1:0]    letter,
  input  wire logic                             msg_end,
  output tptc_pkg::bundle_t                     bundle,
  output logic                                  bundle_push
);
  import tptc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  logic        direction_r;
  logic [59:0] key_low_r;
  logic [59:0] key_mid_r;
  logic [9:0]  key_high_r;
  logic [4:0]  filler_r;

  logic [3:0]  carry_r, carry_nxt;
  logic [1:0]  ccount_r, ccount_nxt;
  logic [RUN_CODE_W-1:0] rcode_r, rcode_nxt;
  logic [2:0]  rlen_r, rlen_nxt;
  logic        rones_r, rones_nxt;
  logic [COUNT_BITS-1:0] tok_r, tok_nxt;
  logic [COUNT_BITS-1:0] leg_r, leg_nxt;

  logic [129:0] keyv;
  assign keyv = {key_high_r, key_mid_r, key_low_r};

  // write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      key_low_r   <= '0;
      key_mid_r   <= '0;
      key_high_r  <= '0;
      filler_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIRECTION: direction_r <= cfg_data[0];
        CFG_KEY_LOW:   key_low_r   <= cfg_data;
        CFG_KEY_MID:   key_mid_r   <= cfg_data;
        CFG_KEY_HIGH:  key_high_r  <= cfg_data[9:0];
        CFG_FILLER:    filler_r    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // classify the beat and build its results
  always_comb begin
    logic [1:0] dig [9];
    logic [2*MAX_CODE_DIGITS-1:0] cw;
    logic [3:0] clen;
    logic [3:0] n;
    logic [1:0] full;
    logic [3:0] b;
    logic [4:0] rk;
    logic       found;
    logic [1:0] rd [3];
    logic [RUN_CODE_W-1:0] code;
    logic [2:0] len;
    logic       ones;
    logic       hit;
    logic [4:0] hl;
    logic [COUNT_BITS-1:0] tok;
    logic [COUNT_BITS-1:0] leg;
    logic [1:0] k;

    bundle     = '0;
    carry_nxt  = carry_r;
    ccount_nxt = ccount_r;
    rcode_nxt  = rcode_r;
    rlen_nxt   = rlen_r;
    rones_nxt  = rones_r;
    tok_nxt    = tok_r;
    leg_nxt    = leg_r;
    tok  = tok_r;
    leg  = leg_r;
    k    = 2'd0;
    cw   = '0;
    clen = 4'd0;
    full = 2'd0;
    b    = 4'd0;
    rk   = 5'd0;
    found = 1'b0;
    code = rcode_r;
    len  = rlen_r;
    ones = rones_r;
    hit  = 1'b0;
    hl   = 5'd0;
    for (int i = 0; i < 9; i++) dig[i] = 2'd1;
    for (int i = 0; i < 3; i++) rd[i] = 2'd1;

    if (!direction_r) begin
      // lay out carry digits, code digits, then one padding
      for (int l = 0; l < NUM_LETTERS; l++) begin
        if (letter == LETTER_W'(l)) begin
          cw   = code_digw(l);
          clen = 4'(code_len(l));
        end
      end
      if (ccount_r == 2'd1) dig[0] = carry_r[1:0];
      if (ccount_r == 2'd2) begin
        dig[0] = carry_r[3:2];
        dig[1] = carry_r[1:0];
      end
      for (int j = 0; j < MAX_CODE_DIGITS; j++) begin
        if (4'(j) < clen) dig[4'(ccount_r) + 4'(j)] = cw[2*j +: 2];
      end
      n = 4'(ccount_r) + clen;
      // cut trigraphs and key them
      for (int t = 0; t < 3; t++) begin
        if ((4'(3*t+3) <= n) || (msg_end && (4'(3*t) < n))) begin
          rk = 5'd9 * {3'b0, dig[3*t] - 2'd1} + 5'd3 * {3'b0, dig[3*t+1] - 2'd1}
             + {3'b0, dig[3*t+2] - 2'd1};
          if (rk > 5'd25) rk = 5'd25;
          bundle.slot[k].letter     = keyv[5*rk +: 5];
          bundle.slot[k].has_letter = 1'b1;
          bundle.slot[k].token_count = OUT_CNT_W'(tok_r);
          bundle.slot[k].legal_count = OUT_CNT_W'(leg_r);
          k = k + 2'd1;
          if (4'(3*t+3) <= n) full = full + 2'd1;
        end
      end
      // keep leftover digits
      b = 4'd3 * {2'b0, full};
      if (n - b == 4'd1) begin
        carry_nxt  = {2'b00, dig[b]};
        ccount_nxt = 2'd1;
      end else if (n - b == 4'd2) begin
        carry_nxt  = {dig[b], dig[b + 4'd1]};
        ccount_nxt = 2'd2;
      end else begin
        carry_nxt  = 4'd0;
        ccount_nxt = 2'd0;
      end
    end else begin
      // inverse key, highest rank wins
      n = 4'd0;
      for (int r = 0; r < NUM_LETTERS; r++) begin
        if (letter < 5'd26 && keyv[5*r +: 5] == letter) begin
          found = 1'b1;
          rd[0] = 2'(r / 9 + 1);
          rd[1] = 2'((r / 3) % 3 + 1);
          rd[2] = 2'(r % 3 + 1);
        end
      end
      // greedy parse of the three digits
      if (found) begin
        for (int s = 0; s < 3; s++) begin
          code = {code[RUN_CODE_W-3:0], rd[s]};
          len  = len + 3'd1;
          if (rd[s] != 2'd1) ones = 1'b0;
          hit = 1'b0;
          for (int l = 0; l < NUM_LETTERS; l++) begin
            if (!hit && code == code_val(l)) begin
              hit = 1'b1;
              hl  = 5'(l);
            end
          end
          if (hit || len >= 3'(MAX_CODE_DIGITS)) begin
            if (tok < CMAX) tok = tok + 1'b1;
            if (hit && leg < CMAX) leg = leg + 1'b1;
            bundle.slot[k].letter      = hit ? hl : filler_r;
            bundle.slot[k].has_letter  = 1'b1;
            bundle.slot[k].token_legal = hit;
            bundle.slot[k].token_count = OUT_CNT_W'(tok);
            bundle.slot[k].legal_count = OUT_CNT_W'(leg);
            k = k + 2'd1;
            code = RUN_CODE_W'(1);
            len  = 3'd0;
            ones = 1'b1;
          end
        end
      end
      // flush a trailing run that is not padding
      if (msg_end && len != 3'd0 && !(ones && len <= 3'd2)) begin
        if (tok < CMAX) tok = tok + 1'b1;
        bundle.slot[k].letter      = filler_r;
        bundle.slot[k].has_letter  = 1'b1;
        bundle.slot[k].token_count = OUT_CNT_W'(tok);
        bundle.slot[k].legal_count = OUT_CNT_W'(leg);
        k = k + 2'd1;
      end
      rcode_nxt = code;
      rlen_nxt  = len;
      rones_nxt = ones;
      tok_nxt   = tok;
      leg_nxt   = leg;
    end

    // close the message
    if (msg_end) begin
      if (k == 2'd0) begin
        bundle.slot[0].token_count = OUT_CNT_W'(tok);
        bundle.slot[0].legal_count = OUT_CNT_W'(leg);
        k = 2'd1;
      end
      bundle.slot[k - 2'd1].run_last = 1'b1;
      carry_nxt  = 4'd0;
      ccount_nxt = 2'd0;
      rcode_nxt  = RUN_CODE_W'(1);
      rlen_nxt   = 3'd0;
      rones_nxt  = 1'b1;
      tok_nxt    = '0;
      leg_nxt    = '0;
    end
    bundle.num = k;
  end

  assign bundle_push = take && (bundle.num != 2'd0);

  // advance message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r  <= 4'd0;
      ccount_r <= 2'd0;
      rcode_r  <= RUN_CODE_W'(1);
      rlen_r   <= 3'd0;
      rones_r  <= 1'b1;
      tok_r    <= '0;
      leg_r    <= '0;
    end else if (take) begin
      carry_r  <= carry_nxt;
      ccount_r <= ccount_nxt;
      rcode_r  <= rcode_nxt;
      rlen_r   <= rlen_nxt;
      rones_r  <= rones_nxt;
      tok_r    <= tok_nxt;
      leg_r    <= leg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tptc_queue.sv -----
// ============================================================================
// tptc_queue
// Two-entry bundle queue between the front and back parts.
// ============================================================================
`default_nettype none
module tptc_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  tptc_pkg::bundle_t wr_data,
  output logic           full,
  input  wire logic      pop,
  output tptc_pkg::bundle_t rd_data,
  output logic           empty
);
  import tptc_pkg::*;

  bundle_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tptc_back.sv -----
// ============================================================================
// tptc_back
// Hands out the results of the head bundle one beat at a time.
// ============================================================================
`default_nettype none
module tptc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  tptc_pkg::bundle_t  head,
  input  wire logic          head_empty,
  output logic               head_pop,
  input  wire logic          take,
  output tptc_pkg::result_t  result
);
  import tptc_pkg::*;

  logic [1:0] idx_r;
  logic       last;

  assign result   = head.slot[idx_r];
  assign last     = (idx_r + 2'd1 == head.num);
  assign head_pop = take && !head_empty && last;

  // step through the slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (take && !head_empty) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ternary_prefix_trigraph_codec.sv -----
// ============================================================================
// ternary_prefix_trigraph_codec
// Letter cipher over a prefix-free ternary code and keyed trigraphs.
// ============================================================================
// Input: one letter per beat on in_letter_in / in_message_end, taken when
// in_push is high and in_full is low. Results come out as a queue: while
// out_empty is low the oldest result is on the out_ ports, and out_pop takes
// it. A letter yields zero to three results; a message end always yields at least one.
// A letter's results enter the queue in the cycle after it is taken. The front
// takes one letter per cycle while the two-entry bundle queue has room; the
// back hands out one result per cycle while out_pop is high, so letters that
// yield several results hold back the input once the queue is full.
// When the receiver stalls, results wait in the queue and in_full rises once
// both entries hold bundles. Configuration writes on cfg_ are always ready
// and must be issued while idle. Reset (synchronous, rst_n low) clears the
// configuration, message state and the queue; no clearing pass follows.
// ============================================================================
`default_nettype none
`include "ternary_prefix_trigraph_codec_macros.svh"
module ternary_prefix_trigraph_codec #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tptc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tptc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic [tptc_pkg::LETTER_W-1:0]    in_letter_in,
  input  wire logic                             in_message_end,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic [tptc_pkg::LETTER_W-1:0]         out_letter_out,
  output logic                                  out_has_letter,
  output logic                                  out_token_legal,
  output logic                                  out_run_last,
  output logic [tptc_pkg::OUT_CNT_W-1:0]        out_token_count,
  output logic [tptc_pkg::OUT_CNT_W-1:0]        out_legal_count
);
  import tptc_pkg::*;

  bundle_t fr_bundle, q_head;
  logic    fr_push, q_full, q_empty, q_pop, take_in;
  result_t res;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign take_in   = in_push && !q_full;
  assign out_empty = q_empty;

  tptc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .take        (take_in),
    .letter      (in_letter_in),
    .msg_end     (in_message_end),
    .bundle      (fr_bundle),
    .bundle_push (fr_push)
  );

  tptc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_push),
    .wr_data (fr_bundle),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  tptc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_empty (q_empty),
    .head_pop   (q_pop),
    .take       (out_pop),
    .result     (res)
  );

  assign out_letter_out  = res.letter;
  assign out_has_letter  = res.has_letter;
  assign out_token_legal = res.token_legal;
  assign out_run_last    = res.run_last;
  assign out_token_count = res.token_count;
  assign out_legal_count = res.legal_count;

  // a pure end marker only closes a message
  `TPTC_ASSERT_IMPL(a_marker_last, clk, rst_n, !out_empty && !out_has_letter, out_run_last)
  // a legal codeword always carries a letter
  `TPTC_ASSERT_IMPL(a_legal_letter, clk, rst_n, !out_empty && out_token_legal, out_has_letter)
  // reset leaves no result waiting
  `TPTC_ASSERT_NEXT(a_reset_empty, clk, !rst_n, out_empty)

endmodule
`default_nettype wire

// ----- tb/trigraph_codec_checker.sv -----
// ----------------------------------------------------------------------------
// trigraph_codec_checker
// Watches the config, letter and result channels of the trigraph codec,
// predicts every result beat from its own model of the cipher and compares
// each popped beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module trigraph_codec_checker
  import tptc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic [LETTER_W-1:0]   in_letter_in,
  input  logic                  in_message_end,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic [LETTER_W-1:0]   out_letter_out,
  input  logic                  out_has_letter,
  input  logic                  out_token_legal,
  input  logic                  out_run_last,
  input  logic [OUT_CNT_W-1:0]  out_token_count,
  input  logic [OUT_CNT_W-1:0]  out_legal_count,
  output int                    fail_count,
  output int                    pending,
  output int                    letters_taken,
  output int                    beats_checked,
  output int                    legal_tokens,
  output int                    filler_tokens
);

  localparam int CNT_MAX = 65535;

  // letter codes, digits 1..3 written in decimal
  localparam int LETTER_CODE [26] = '{
    13, 32112, 1112, 213, 31, 3213, 32113, 113,
    322, 321112, 11112, 212, 2111, 23, 22, 3212,
    11113, 323, 112, 12, 1113, 11111, 2112, 321111,
    2113, 321113
  };

  result_t expected_beats[$];

  // shadow configuration
  logic        dir_decipher;
  logic [59:0] key_low, key_mid;
  logic [9:0]  key_high;
  logic [4:0]  filler;

  // shadow message state
  logic [3:0]  enc_carry;
  int          enc_count;
  logic [12:0] parse_code;
  int          parse_len;
  logic        parse_ones;
  int          tokens, legals;

  // per-letter scratch
  result_t     step_beats[4];
  int          step_n;
  int          code_value[26];

  initial begin
    string s;
    for (int l = 0; l < 26; l++) begin
      s = $sformatf("%0d", LETTER_CODE[l]);
      code_value[l] = 1;
      for (int i = 0; i < s.len(); i++) code_value[l] = code_value[l] * 4 + (s[i] - "0");
    end
  end

  function automatic logic [4:0] keyed_letter(int r);
    if (r > 25) r = 25;
    if (r < 12) return key_low[5*r +: 5];
    if (r < 24) return key_mid[5*(r-12) +: 5];
    return key_high[5*(r-24) +: 5];
  endfunction

  task automatic add_beat(logic [4:0] l, logic has, logic legal);
    result_t b;
    b.letter      = l;
    b.has_letter  = has;
    b.token_legal = legal;
    b.run_last    = 1'b0;
    b.token_count = OUT_CNT_W'(tokens);
    b.legal_count = OUT_CNT_W'(legals);
    step_beats[step_n] = b;
    step_n++;
  endtask

  task automatic cipher_digit(int d);
    int a, b;
    if (enc_count >= 2) begin
      a = enc_carry[3:2];
      b = enc_carry[1:0];
      add_beat(keyed_letter(9*((a+2)%3) + 3*((b+2)%3) + (d+2)%3), 1'b1, 1'b0);
      enc_carry = '0;
      enc_count = 0;
    end else begin
      enc_carry = {enc_carry[1:0], 2'(d)};
      enc_count++;
    end
  endtask

  task automatic clear_parse();
    parse_code = 13'd1;
    parse_len  = 0;
    parse_ones = 1'b1;
  endtask

  task automatic parse_digit(int d);
    int hit;
    hit = -1;
    parse_code = {parse_code[10:0], 2'(d)};
    parse_len++;
    if (d != 1) parse_ones = 1'b0;
    for (int l = 0; l < 26; l++) if (code_value[l] == int'(parse_code)) hit = l;
    if (hit >= 0) begin
      if (tokens < CNT_MAX) tokens++;
      if (legals < CNT_MAX) legals++;
      add_beat(5'(hit), 1'b1, 1'b1);
      clear_parse();
    end else if (parse_len >= 6) begin
      if (tokens < CNT_MAX) tokens++;
      add_beat(filler, 1'b1, 1'b0);
      clear_parse();
    end
  endtask

  task automatic clear_message();
    enc_carry = '0;
    enc_count = 0;
    clear_parse();
    tokens = 0;
    legals = 0;
  endtask

  // work out every result beat of one accepted letter
  task automatic predict_letter(logic [4:0] l, logic last);
    string s;
    int rank;
    step_n = 0;
    if (!dir_decipher) begin
      if (l < 26) begin
        s = $sformatf("%0d", LETTER_CODE[l]);
        for (int i = 0; i < s.len(); i++) cipher_digit(s[i] - "0");
      end
      if (last) while (enc_count != 0) cipher_digit(1);
    end else begin
      rank = -1;
      if (l < 26) for (int r = 0; r < 26; r++) if (keyed_letter(r) == l) rank = r;
      if (rank >= 0) begin
        parse_digit(rank / 9 + 1);
        parse_digit((rank / 3) % 3 + 1);
        parse_digit(rank % 3 + 1);
      end
      if (last && parse_len > 0 && !(parse_ones && parse_len <= 2)) begin
        if (tokens < CNT_MAX) tokens++;
        add_beat(filler, 1'b1, 1'b0);
      end
    end
    if (last) begin
      if (step_n == 0) add_beat(5'd0, 1'b0, 1'b0);
      step_beats[step_n-1].run_last = 1'b1;
      clear_message();
    end
    for (int i = 0; i < step_n; i++) expected_beats.push_back(step_beats[i]);
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // compare one popped beat with the oldest prediction
  task automatic check_beat();
    result_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat letter=%0d", out_letter_out));
      return;
    end
    want = expected_beats.pop_front();
    beats_checked++;
    if (out_letter_out !== want.letter)
      report_mismatch($sformatf("letter_out %0d, want %0d", out_letter_out, want.letter));
    if (out_has_letter !== want.has_letter)
      report_mismatch($sformatf("has_letter %0b, want %0b", out_has_letter, want.has_letter));
    if (out_token_legal !== want.token_legal)
      report_mismatch($sformatf("token_legal %0b, want %0b", out_token_legal,
                                want.token_legal));
    if (out_run_last !== want.run_last)
      report_mismatch($sformatf("run_last %0b, want %0b", out_run_last, want.run_last));
    if (out_token_count !== want.token_count)
      report_mismatch($sformatf("token_count %0d, want %0d", out_token_count,
                                want.token_count));
    if (out_legal_count !== want.legal_count)
      report_mismatch($sformatf("legal_count %0d, want %0d", out_legal_count,
                                want.legal_count));
    if (want.has_letter && dir_decipher) begin
      if (want.token_legal) legal_tokens++;
      else filler_tokens++;
    end
  endtask

  initial begin
    fail_count    = 0;
    letters_taken = 0;
    beats_checked = 0;
    legal_tokens  = 0;
    filler_tokens = 0;
  end

  // sample all channels at the rising edge: config, then letters, then results
  always @(posedge clk) begin
    if (!rst_n) begin
      dir_decipher = 1'b0;
      key_low  = '0;
      key_mid  = '0;
      key_high = '0;
      filler   = '0;
      clear_message();
      expected_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIRECTION: dir_decipher = cfg_data[0];
          CFG_KEY_LOW:   key_low  = cfg_data[59:0];
          CFG_KEY_MID:   key_mid  = cfg_data[59:0];
          CFG_KEY_HIGH:  key_high = cfg_data[9:0];
          CFG_FILLER:    filler   = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        letters_taken++;
        predict_letter(in_letter_in, in_message_end);
      end
      if (out_pop && !out_empty) check_beat();
    end
    pending = expected_beats.size();
  end

endmodule

// ----- tb/ternary_prefix_trigraph_codec_test.sv -----
// ----------------------------------------------------------------------------
// ternary_prefix_trigraph_codec_test
// Drives letters and key settings into the trigraph codec in both directions,
// with random gaps on the letter side and random stalls on the result side;
// the checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module ternary_prefix_trigraph_codec_test;
  import tptc_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [LETTER_W-1:0]   in_letter_in = '0;
  logic                  in_message_end = 1'b0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [LETTER_W-1:0]   out_letter_out;
  logic                  out_has_letter, out_token_legal, out_run_last;
  logic [OUT_CNT_W-1:0]  out_token_count, out_legal_count;

  int fail_count, pending, letters_taken, beats_checked, legal_tokens, filler_tokens;
  int stall_mode = 0;

  always #5 clk = ~clk;

  ternary_prefix_trigraph_codec u_dut (.*);

  trigraph_codec_checker u_checker (.*);

  // short gaps mostly, a few long ones
  function automatic int gap_cycles();
    int p;
    p = $urandom_range(0, 99);
    if (stall_mode == 0) return 0;
    if (p < 70) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // result side: random pop stalls, switched off in some stretches
  always @(negedge clk) begin
    if (stall_mode == 0) out_pop = 1'b1;
    else out_pop = ($urandom_range(0, 99) < 65);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // send one letter beat, hold until it is taken
  task automatic send_letter(logic [4:0] l, logic last);
    int g;
    g = gap_cycles();
    if (g > 0) begin
      in_push = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_letter_in   = l;
    in_message_end = last;
    in_push        = 1'b1;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // drop push and let every predicted beat drain
  task automatic drain();
    in_push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_key(int style);
    logic [4:0] k[26];
    logic [4:0] t;
    int j;
    logic [129:0] packed_key;
    for (int i = 0; i < 26; i++) k[i] = 5'(i);
    for (int i = 25; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = k[i]; k[i] = k[j]; k[j] = t;
    end
    for (int i = 0; i < 26; i++) begin
      if (style == 1) k[i] = 5'($urandom_range(0, 31));
      if (style == 2) k[i] = 5'd31;
      if (style == 3) k[i] = 5'd0;
    end
    for (int i = 0; i < 26; i++) packed_key[5*i +: 5] = k[i];
    write_reg(CFG_KEY_LOW,  60'(packed_key[59:0]));
    write_reg(CFG_KEY_MID,  60'(packed_key[119:60]));
    write_reg(CFG_KEY_HIGH, 60'(packed_key[129:120]));
  endtask

  task automatic random_message_run(int count, bit flip_mid);
    logic [4:0] l;
    for (int i = 0; i < count; i++) begin
      l = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                      : 5'($urandom_range(0, 25));
      send_letter(l, ($urandom_range(0, 7) == 0) || (i == count - 1));
      if (flip_mid && i == count / 2) begin
        drain();
        write_reg(CFG_DIRECTION, 60'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: encipher every letter with a shuffled key, skip codes, bare end
    load_key(0);
    write_reg(CFG_FILLER, 60'd31);
    write_reg(CFG_DIRECTION, 60'd0);
    for (int l = 0; l < 26; l++) send_letter(5'(l), (l % 9) == 8);
    send_letter(5'd31, 1'b1);
    send_letter(5'd26, 1'b1);
    drain();

    // directed: decipher, including a letter absent from the key and padding
    write_reg(CFG_DIRECTION, 60'd1);
    send_letter(5'd0, 1'b0);
    send_letter(5'd31, 1'b1);
    send_letter(5'd25, 1'b1);
    send_letter(5'd13, 1'b0);
    send_letter(5'd7, 1'b1);
    drain();

    // random: both directions, shuffled and duplicate keys, extremes
    stall_mode = 1;
    write_reg(CFG_DIRECTION, 60'd0);
    random_message_run(50, 0);
    drain();
    write_reg(CFG_DIRECTION, 60'd1);
    write_reg(CFG_FILLER, 60'd0);
    random_message_run(50, 0);
    drain();
    load_key(1);
    write_reg(CFG_FILLER, 60'($urandom_range(0, 31)));
    random_message_run(30, 0);
    drain();
    stall_mode = 0;
    write_reg(CFG_DIRECTION, 60'd0);
    random_message_run(20, 1);
    drain();
    stall_mode = 1;
    load_key(2);
    write_reg(CFG_DIRECTION, 60'd1);
    random_message_run(10, 0);
    drain();
    load_key(3);
    write_reg(CFG_DIRECTION, 60'd0);
    random_message_run(10, 0);
    drain();
    load_key(0);
    random_message_run(20, 1);
    drain();

    repeat (10) @(negedge clk);
    $display("covered %0d letters and %0d result beats in both directions",
             letters_taken, beats_checked);
    $display("deciphered %0d legal codewords and %0d filler tokens",
             legal_tokens, filler_tokens);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
